// ----- hw/rtl/vau_pkg.sv -----
// Shared types, opcodes and helpers for the three-component vector unit.
// Depends on nothing; the top level imports it.
package vau_pkg;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_DOT       = 4'd2,
        OP_CROSS     = 4'd3,
        OP_SCALE     = 4'd4,
        OP_EACHMUL   = 4'd5,
        OP_NORMALIZE = 4'd6,
        OP_LENGTH    = 4'd7,
        OP_DISTANCE  = 4'd8,
        OP_NORMAL    = 4'd9,
        OP_CENTROID  = 4'd10,
        OP_CLAMP     = 4'd11
    } t_opcode;

    typedef struct packed {
        logic        [3:0]  opcode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
        logic signed [31:0] scale_factor;
    } t_vec_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_scalar;
        logic               ok;
    } t_vec_out;

    // Side data that travels with an item through the back half of the pipe
    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] r;
        logic [31:0]      sc;
        logic             ok;
        logic [2:0]       neg;
        logic [2:0][29:0] m;
        logic [31:0]      root;
    } t_carry;

    // Normalized magnitudes put their leading one at this bit
    localparam logic [5:0]  NORM_MSB   = 6'd29;
    // ceil(2^35 / 3): exact divide by three for magnitudes below 2^33
    localparam logic [33:0] DIV3_RECIP = 34'd11453246123;
    localparam int          DIV3_SHIFT = 35;

    function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
        sx66 = {{34{v[31]}}, v};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic hi_same;
        hi_same = (v[65:31] == '0) || (v[65:31] == '1);
        if (hi_same) begin
            sat32 = v[31:0];
        end else if (v[65]) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = 32'h7FFF_FFFF;
        end
    endfunction

endpackage

// ----- hw/rtl/vector3_arith_unit.sv -----
// Top level of the three-component vector unit (signed Q16.16 by default).
// Uses vau_pkg, vau_sqrt and vau_div.
//
// Usage:
//   Input channel: drive i_item and raise start; the item is taken at each
//   rising edge where start is high and busy is low. busy never rises, so one
//   item may enter every cycle, back to back, with no gaps.
//   Result channel: o_result is valid for exactly one cycle while o_strobe is
//   high; the receiver has no way to stall and must take it on that edge.
//   Order: every opcode takes the same path from the accepting edge to the
//   strobe, so results leave in the order items entered.
//   Throughput: one item per cycle. The depth is set by eight front stages
//   (operand select, multiply, combine, magnitude, leading-one search, shift,
//   square, sum), the 16-stage square-root pipe (two root bits per stage),
//   the divider pipe (at most two quotient bits each) and the output register.
//   Reset: synchronous, active low; clears every stage valid bit, so items in
//   flight are dropped and no strobe follows. Data registers are not reset.
//   Undefined opcodes give zero vector, zero scalar and ok low.
module vector3_arith_unit
    import vau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_vec_in  i_item,
    output logic     o_strobe,
    output t_vec_out o_result
);

    localparam int PAY_W = $bits(t_carry);

    // The pipe never stalls
    assign busy = 1'b0;

    function automatic logic signed [65:0] sx66_64(input logic signed [63:0] v);
        sx66_64 = {{2{v[63]}}, v};
    endfunction

    function automatic logic is_norm(input logic [3:0] op);
        is_norm = (op == OP_NORMALIZE) || (op == OP_NORMAL);
    endfunction

    // ------------------------------------------------------------------
    // Stage 1: add/sub/clamp, differences, centroid sum, multiplier operands
    // ------------------------------------------------------------------
    logic signed [31:0] ia [3];
    logic signed [31:0] ib [3];
    logic signed [31:0] ic [3];

    logic               r1_valid;
    logic [3:0]         r1_op;
    logic signed [31:0] r1_ma [6];
    logic signed [31:0] r1_mb [6];
    logic [2:0][31:0]   r1_r;
    logic [32:0]        r1_cabs [3];
    logic [2:0]         r1_cneg;

    logic signed [31:0] n1_ma [6];
    logic signed [31:0] n1_mb [6];
    logic [2:0][31:0]   n1_r;
    logic [32:0]        n1_cabs [3];
    logic [2:0]         n1_cneg;

    assign ia[0] = i_item.a_x;
    assign ia[1] = i_item.a_y;
    assign ia[2] = i_item.a_z;
    assign ib[0] = i_item.b_x;
    assign ib[1] = i_item.b_y;
    assign ib[2] = i_item.b_z;
    assign ic[0] = i_item.c_x;
    assign ic[1] = i_item.c_y;
    assign ic[2] = i_item.c_z;

    always_comb begin
        logic signed [31:0] addv [3];
        logic signed [31:0] subv [3];
        logic signed [31:0] d1   [3];
        logic signed [31:0] d2   [3];
        logic signed [31:0] clv  [3];
        logic signed [31:0] u    [3];
        logic signed [31:0] v    [3];
        logic signed [33:0] cs;
        for (int i = 0; i < 3; i++) begin
            addv[i] = sat32(sx66(ia[i]) + sx66(ib[i]));
            subv[i] = sat32(sx66(ia[i]) - sx66(ib[i]));
            d1[i]   = sat32(sx66(ib[i]) - sx66(ia[i]));
            d2[i]   = sat32(sx66(ic[i]) - sx66(ia[i]));
            clv[i]  = ia[i];
            if (clv[i] < ib[i]) begin
                clv[i] = ib[i];
            end
            if (clv[i] > ic[i]) begin
                clv[i] = ic[i];
            end
            cs         = 34'(sx66(ia[i]) + sx66(ib[i]) + sx66(ic[i]));
            n1_cneg[i] = cs[33];
            n1_cabs[i] = cs[33] ? 33'(-cs) : cs[32:0];
        end

        // Cross operands: u = a or b-a, v = b or c-a
        for (int i = 0; i < 3; i++) begin
            u[i] = (i_item.opcode == OP_NORMAL) ? d1[i] : ia[i];
            v[i] = (i_item.opcode == OP_NORMAL) ? d2[i] : ib[i];
        end

        for (int k = 0; k < 6; k++) begin
            n1_ma[k] = '0;
            n1_mb[k] = '0;
        end
        n1_r = '0;

        case (i_item.opcode)
            OP_ADD: begin
                for (int i = 0; i < 3; i++) n1_r[i] = addv[i];
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) n1_r[i] = subv[i];
            end
            OP_CLAMP: begin
                for (int i = 0; i < 3; i++) n1_r[i] = clv[i];
            end
            OP_NORMALIZE: begin
                for (int i = 0; i < 3; i++) n1_r[i] = ia[i];
            end
            OP_DOT, OP_EACHMUL: begin
                for (int i = 0; i < 3; i++) begin
                    n1_ma[i] = ia[i];
                    n1_mb[i] = ib[i];
                end
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n1_ma[i] = i_item.scale_factor;
                    n1_mb[i] = ia[i];
                end
            end
            OP_LENGTH: begin
                for (int i = 0; i < 3; i++) begin
                    n1_ma[i] = ia[i];
                    n1_mb[i] = ia[i];
                end
            end
            OP_DISTANCE: begin
                for (int i = 0; i < 3; i++) begin
                    n1_ma[i] = subv[i];
                    n1_mb[i] = subv[i];
                end
            end
            OP_CROSS, OP_NORMAL: begin
                n1_ma[0] = u[1]; n1_mb[0] = v[2];
                n1_ma[1] = v[1]; n1_mb[1] = u[2];
                n1_ma[2] = u[2]; n1_mb[2] = v[0];
                n1_ma[3] = v[2]; n1_mb[3] = u[0];
                n1_ma[4] = u[0]; n1_mb[4] = v[1];
                n1_ma[5] = v[0]; n1_mb[5] = u[1];
            end
            default: begin
                n1_r = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r1_op   <= i_item.opcode;
            r1_ma   <= n1_ma;
            r1_mb   <= n1_mb;
            r1_r    <= n1_r;
            r1_cabs <= n1_cabs;
            r1_cneg <= n1_cneg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: six 32x32 products, centroid divide by three
    // ------------------------------------------------------------------
    logic               r2_valid;
    logic [3:0]         r2_op;
    logic signed [63:0] r2_p [6];
    logic [2:0][31:0]   r2_r;
    logic [31:0]        r2_cq [3];
    logic [2:0]         r2_cneg;

    logic signed [63:0] n2_p  [6];
    logic [31:0]        n2_cq [3];

    always_comb begin
        logic [66:0] cprod;
        for (int k = 0; k < 6; k++) begin
            n2_p[k] = r1_ma[k] * r1_mb[k];
        end
        for (int i = 0; i < 3; i++) begin
            cprod    = 67'(r1_cabs[i]) * 67'(DIV3_RECIP);
            n2_cq[i] = cprod[DIV3_SHIFT +: 32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid) begin
            r2_op   <= r1_op;
            r2_p    <= n2_p;
            r2_r    <= r1_r;
            r2_cq   <= n2_cq;
            r2_cneg <= r1_cneg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: combine products, floor shift, saturate
    // ------------------------------------------------------------------
    logic               r3_valid;
    t_carry             r3_c;
    logic signed [64:0] r3_nv [3];
    logic [63:0]        r3_usq;

    t_carry             n3_c;
    logic signed [64:0] n3_nv [3];
    logic [63:0]        n3_usq;

    always_comb begin
        logic signed [65:0] e  [6];
        logic signed [65:0] df [3];
        logic signed [65:0] dsum;
        for (int k = 0; k < 6; k++) begin
            e[k] = sx66_64(r2_p[k]);
        end
        df[0] = e[0] - e[1];
        df[1] = e[2] - e[3];
        df[2] = e[4] - e[5];
        dsum  = e[0] + e[1] + e[2];

        n3_c    = '0;
        n3_c.op = r2_op;
        n3_c.ok = (r2_op <= OP_CLAMP);
        n3_usq  = 64'(r2_p[0]) + 64'(r2_p[1]) + 64'(r2_p[2]);
        for (int i = 0; i < 3; i++) begin
            n3_nv[i] = '0;
        end

        case (r2_op)
            OP_ADD, OP_SUB, OP_CLAMP: begin
                n3_c.r = r2_r;
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) n3_c.r[i] = sat32(df[i] >>> FRAC_BITS);
            end
            OP_SCALE, OP_EACHMUL: begin
                for (int i = 0; i < 3; i++) n3_c.r[i] = sat32(e[i] >>> FRAC_BITS);
            end
            OP_DOT: begin
                n3_c.sc = sat32(dsum >>> FRAC_BITS);
            end
            OP_CENTROID: begin
                for (int i = 0; i < 3; i++) begin
                    n3_c.r[i] = r2_cneg[i] ? 32'(-r2_cq[i]) : r2_cq[i];
                end
            end
            OP_NORMALIZE: begin
                for (int i = 0; i < 3; i++) n3_nv[i] = 65'($signed(r2_r[i]));
            end
            OP_NORMAL: begin
                for (int i = 0; i < 3; i++) n3_nv[i] = df[i][64:0];
            end
            default: begin
                n3_c.sc = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_valid) begin
            r3_c   <= n3_c;
            r3_nv  <= n3_nv;
            r3_usq <= n3_usq;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: split normalize input into sign and magnitude
    // ------------------------------------------------------------------
    logic        r4_valid;
    t_carry      r4_c;
    logic [63:0] r4_mag [3];
    logic [63:0] r4_usq;

    t_carry      n4_c;
    logic [63:0] n4_mag [3];

    always_comb begin
        logic signed [64:0] ng;
        n4_c = r3_c;
        for (int i = 0; i < 3; i++) begin
            ng          = -r3_nv[i];
            n4_c.neg[i] = r3_nv[i][64];
            n4_mag[i]   = r3_nv[i][64] ? ng[63:0] : r3_nv[i][63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r3_valid) begin
            r4_c   <= n4_c;
            r4_mag <= n4_mag;
            r4_usq <= r3_usq;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: leading-one search over the largest magnitude
    // ------------------------------------------------------------------
    logic        r5_valid;
    t_carry      r5_c;
    logic [63:0] r5_mag [3];
    logic [5:0]  r5_pos;
    logic [63:0] r5_usq;

    t_carry      n5_c;
    logic [5:0]  n5_pos;

    always_comb begin
        logic [63:0] any;
        any    = r4_mag[0] | r4_mag[1] | r4_mag[2];
        n5_pos = '0;
        for (int k = 0; k < 64; k++) begin
            if (any[k]) begin
                n5_pos = 6'(k);
            end
        end
        n5_c = r4_c;
        if (is_norm(r4_c.op)) begin
            n5_c.ok = (any != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r4_valid) begin
            r5_c   <= n5_c;
            r5_mag <= r4_mag;
            r5_pos <= n5_pos;
            r5_usq <= r4_usq;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: shift all magnitudes so the largest sits at NORM_MSB
    // ------------------------------------------------------------------
    logic        r6_valid;
    t_carry      r6_c;
    logic [63:0] r6_usq;

    t_carry      n6_c;

    always_comb begin
        logic [63:0] sh;
        n6_c = r5_c;
        for (int i = 0; i < 3; i++) begin
            if (r5_pos >= NORM_MSB) begin
                sh = r5_mag[i] >> 6'(r5_pos - NORM_MSB);
            end else begin
                sh = r5_mag[i] << 6'(NORM_MSB - r5_pos);
            end
            n6_c.m[i] = sh[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r5_valid) begin
            r6_c   <= n6_c;
            r6_usq <= r5_usq;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: square the normalized magnitudes
    // ------------------------------------------------------------------
    logic        r7_valid;
    t_carry      r7_c;
    logic [59:0] r7_sq [3];
    logic [63:0] r7_usq;

    logic [59:0] n7_sq [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n7_sq[i] = 60'(r6_c.m[i]) * 60'(r6_c.m[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r6_valid) begin
            r7_c   <= r6_c;
            r7_sq  <= n7_sq;
            r7_usq <= r6_usq;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: pick the square-root operand
    // ------------------------------------------------------------------
    logic        r8_valid;
    t_carry      r8_c;
    logic [63:0] r8_rad;

    logic [63:0] n8_rad;

    always_comb begin
        if (is_norm(r7_c.op)) begin
            n8_rad = 64'(r7_sq[0]) + 64'(r7_sq[1]) + 64'(r7_sq[2]);
        end else begin
            n8_rad = r7_usq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else begin
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r7_valid) begin
            r8_c   <= r7_c;
            r8_rad <= n8_rad;
        end
    end

    // ------------------------------------------------------------------
    // Square root, then the three-lane divide by the length
    // ------------------------------------------------------------------
    logic             sq_valid;
    logic [31:0]      sq_root;
    logic [PAY_W-1:0] sq_pay;
    t_carry           sq_c;

    vau_sqrt #(
        .PAY_W (PAY_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r8_valid),
        .i_radicand (r8_rad),
        .i_pay      (r8_c),
        .o_valid    (sq_valid),
        .o_root     (sq_root),
        .o_pay      (sq_pay)
    );

    always_comb begin
        sq_c      = t_carry'(sq_pay);
        sq_c.root = sq_root;
    end

    logic                    dv_valid;
    logic [2:0][FRAC_BITS:0] dv_quo;
    logic [PAY_W-1:0]        dv_pay;
    t_carry                  dv_c;

    vau_div #(
        .FRAC_BITS (FRAC_BITS),
        .PAY_W     (PAY_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_den   (sq_root),
        .i_num   (sq_c.m),
        .i_pay   (sq_c),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_pay   (dv_pay)
    );

    assign dv_c = t_carry'(dv_pay);

    // ------------------------------------------------------------------
    // Output register: final selection per opcode
    // ------------------------------------------------------------------
    logic     r_strobe;
    t_vec_out r_result;
    t_vec_out n_result;

    always_comb begin
        logic [31:0] qv  [3];
        logic [31:0] vec [3];
        for (int i = 0; i < 3; i++) begin
            qv[i]  = 32'(dv_quo[i]);
            vec[i] = dv_c.r[i];
        end
        n_result.out_scalar = dv_c.sc;
        n_result.ok         = dv_c.ok;
        case (dv_c.op)
            OP_NORMALIZE, OP_NORMAL: begin
                for (int i = 0; i < 3; i++) begin
                    if (!dv_c.ok) begin
                        vec[i] = '0;
                    end else begin
                        vec[i] = dv_c.neg[i] ? 32'(-qv[i]) : qv[i];
                    end
                end
                n_result.out_scalar = '0;
            end
            OP_LENGTH, OP_DISTANCE: begin
                for (int i = 0; i < 3; i++) vec[i] = '0;
                // Hold the root below 2^31
                n_result.out_scalar = dv_c.root[31] ? 32'h7FFF_FFFF : dv_c.root;
            end
            default: begin
                n_result.ok = dv_c.ok;
            end
        endcase
        n_result.out_x = vec[0];
        n_result.out_y = vec[1];
        n_result.out_z = vec[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_valid) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- hw/rtl/vau_sqrt.sv -----
// Pipelined integer square root, 64-bit radicand, 32-bit floor root.
// Two restoring digit steps per stage; side data rides along. No package use.
module vau_sqrt #(
    parameter int PAY_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [63:0]      i_radicand,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [31:0]      o_root,
    output logic [PAY_W-1:0] o_pay
);

    localparam int STAGES = 16;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } t_sq_state;

    function automatic t_sq_state sq_step(input t_sq_state s);
        logic [34:0] rem_sh;
        logic [34:0] trial;
        t_sq_state   n;
        rem_sh = {s.rem, s.rad[63:62]};
        trial  = {1'b0, s.root, 2'b01};
        n.rad  = {s.rad[61:0], 2'b00};
        if (rem_sh >= trial) begin
            n.rem  = 33'(rem_sh - trial);
            n.root = {s.root[30:0], 1'b1};
        end else begin
            n.rem  = rem_sh[32:0];
            n.root = {s.root[30:0], 1'b0};
        end
        sq_step = n;
    endfunction

    t_sq_state        r_st  [STAGES];
    logic             r_vld [STAGES];
    logic [PAY_W-1:0] r_pay [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        t_sq_state        prev_st;
        logic             prev_vld;
        logic [PAY_W-1:0] prev_pay;
        t_sq_state        n_st;

        if (s == 0) begin : g_first
            assign prev_st  = '{rem: '0, root: '0, rad: i_radicand};
            assign prev_vld = i_valid;
            assign prev_pay = i_pay;
        end else begin : g_next
            assign prev_st  = r_st[s-1];
            assign prev_vld = r_vld[s-1];
            assign prev_pay = r_pay[s-1];
        end

        assign n_st = sq_step(sq_step(prev_st));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= prev_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (prev_vld) begin
                r_st[s]  <= n_st;
                r_pay[s] <= prev_pay;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_root  = r_st[STAGES-1].root;
    assign o_pay   = r_pay[STAGES-1];

endmodule

// ----- hw/rtl/vau_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor:
// quotient = floor(num * 2^FRAC_BITS / den). Up to two steps per stage. No package use.
module vau_div #(
    parameter int FRAC_BITS = 16,
    parameter int PAY_W     = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [31:0]               i_den,
    input  logic [2:0][29:0]          i_num,
    input  logic [PAY_W-1:0]          i_pay,
    output logic                      o_valid,
    output logic [2:0][FRAC_BITS:0]   o_quo,
    output logic [PAY_W-1:0]          o_pay
);

    localparam int QW     = FRAC_BITS + 1;
    localparam int STAGES = (QW + 1) / 2;

    typedef struct packed {
        logic [31:0]   rem;
        logic          nbit;
        logic [QW-1:0] q;
    } t_lane;

    function automatic t_lane div_step(input t_lane s, input logic [31:0] den);
        logic [32:0] rem_sh;
        t_lane       n;
        rem_sh = {s.rem, s.nbit};
        n.nbit = 1'b0;
        if (rem_sh >= {1'b0, den}) begin
            n.rem = 32'(rem_sh - {1'b0, den});
            n.q   = {s.q[QW-2:0], 1'b1};
        end else begin
            n.rem = rem_sh[31:0];
            n.q   = {s.q[QW-2:0], 1'b0};
        end
        div_step = n;
    endfunction

    t_lane            r_ln  [STAGES][3];
    logic [31:0]      r_den [STAGES];
    logic             r_vld [STAGES];
    logic [PAY_W-1:0] r_pay [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        t_lane            prev_ln [3];
        logic [31:0]      prev_den;
        logic             prev_vld;
        logic [PAY_W-1:0] prev_pay;
        t_lane            n_ln    [3];

        if (s == 0) begin : g_first
            for (genvar l = 0; l < 3; l++) begin : g_init
                assign prev_ln[l] = '{rem: 32'(i_num[l][29:1]), nbit: i_num[l][0], q: '0};
            end
            assign prev_den = i_den;
            assign prev_vld = i_valid;
            assign prev_pay = i_pay;
        end else begin : g_next
            for (genvar l = 0; l < 3; l++) begin : g_link
                assign prev_ln[l] = r_ln[s-1][l];
            end
            assign prev_den = r_den[s-1];
            assign prev_vld = r_vld[s-1];
            assign prev_pay = r_pay[s-1];
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_ln[l] = prev_ln[l];
                for (int j = 0; j < 2; j++) begin
                    if (2 * s + j < QW) begin
                        n_ln[l] = div_step(n_ln[l], prev_den);
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= prev_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (prev_vld) begin
                for (int l = 0; l < 3; l++) begin
                    r_ln[s][l] <= n_ln[l];
                end
                r_den[s] <= prev_den;
                r_pay[s] <= prev_pay;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_pay   = r_pay[STAGES-1];
    for (genvar l = 0; l < 3; l++) begin : g_out
        assign o_quo[l] = r_ln[STAGES-1][l].q;
    end

endmodule

// ----- bench/vau_result_checker.sv -----
// Result checker for the vector unit: predicts each accepted item, compares results.
// Depends on vau_pkg; instantiated by vector3_arith_unit_test beside the DUT.
module vau_result_checker
    import vau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_vec_in  i_item,
    input  logic     i_strobe,
    input  t_vec_out i_result,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [129:0] t_wide;
    localparam int FRAC = 16;

    t_vec_out expected_results[$];

    function automatic logic [31:0] clip32(input t_wide v);
        if (v > t_wide'(64'sd2147483647)) return 32'h7FFF_FFFF;
        if (v < -t_wide'(64'sd2147483648)) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [127:0] root_floor(input logic [127:0] v);
        logic [127:0] res;
        logic [127:0] bitv;
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scale magnitudes so the largest has its top bit at 29, then divide by the root.
    function automatic logic unit_vector(input t_wide v [3], output logic [31:0] o [3]);
        logic [127:0] m [3];
        logic [127:0] mx;
        logic [127:0] len;
        t_wide q;
        for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? 128'(-v[i]) : 128'(v[i]);
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) o[i] = '0;
            return 1'b0;
        end
        while (mx >= (128'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (128'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = t_wide'((m[i] << FRAC) / len);
            o[i] = clip32(v[i] < 0 ? -q : q);
        end
        return 1'b1;
    endfunction

    function automatic t_vec_out predict_vector_op(input t_vec_in it);
        t_wide a [3];
        t_wide b [3];
        t_wide c [3];
        t_wide d1 [3];
        t_wide d2 [3];
        t_wide n [3];
        t_wide s;
        t_wide acc;
        logic [127:0] sq;
        logic [31:0] r [3];
        t_vec_out res;
        a = '{t_wide'(it.a_x), t_wide'(it.a_y), t_wide'(it.a_z)};
        b = '{t_wide'(it.b_x), t_wide'(it.b_y), t_wide'(it.b_z)};
        c = '{t_wide'(it.c_x), t_wide'(it.c_y), t_wide'(it.c_z)};
        s = t_wide'(it.scale_factor);
        r = '{32'd0, 32'd0, 32'd0};
        res = '0;
        res.ok = 1'b1;
        case (it.opcode)
            OP_ADD: for (int i = 0; i < 3; i++) r[i] = clip32(a[i] + b[i]);
            OP_SUB: for (int i = 0; i < 3; i++) r[i] = clip32(a[i] - b[i]);
            OP_DOT: begin
                acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                res.out_scalar = clip32(acc >>> FRAC);
            end
            OP_CROSS: begin
                r[0] = clip32((a[1] * b[2] - b[1] * a[2]) >>> FRAC);
                r[1] = clip32((a[2] * b[0] - b[2] * a[0]) >>> FRAC);
                r[2] = clip32((a[0] * b[1] - b[0] * a[1]) >>> FRAC);
            end
            OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clip32((s * a[i]) >>> FRAC);
            OP_EACHMUL: for (int i = 0; i < 3; i++) r[i] = clip32((a[i] * b[i]) >>> FRAC);
            OP_NORMALIZE: res.ok = unit_vector(a, r);
            OP_LENGTH: begin
                sq = 128'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                res.out_scalar = clip32(t_wide'(root_floor(sq)));
            end
            OP_DISTANCE: begin
                for (int i = 0; i < 3; i++) d1[i] = t_wide'(signed'(clip32(a[i] - b[i])));
                sq = 128'(d1[0] * d1[0] + d1[1] * d1[1] + d1[2] * d1[2]);
                res.out_scalar = clip32(t_wide'(root_floor(sq)));
            end
            OP_NORMAL: begin
                for (int i = 0; i < 3; i++) begin
                    d1[i] = t_wide'(signed'(clip32(b[i] - a[i])));
                    d2[i] = t_wide'(signed'(clip32(c[i] - a[i])));
                end
                n[0] = d1[1] * d2[2] - d2[1] * d1[2];
                n[1] = d1[2] * d2[0] - d2[2] * d1[0];
                n[2] = d1[0] * d2[1] - d2[0] * d1[1];
                res.ok = unit_vector(n, r);
            end
            OP_CENTROID: for (int i = 0; i < 3; i++) r[i] = clip32((a[i] + b[i] + c[i]) / 3);
            OP_CLAMP: begin
                for (int i = 0; i < 3; i++) begin
                    acc = a[i];
                    if (acc < b[i]) acc = b[i];
                    if (acc > c[i]) acc = c[i];
                    r[i] = acc[31:0];
                end
            end
            default: res.ok = 1'b0;
        endcase
        res.out_x = r[0];
        res.out_y = r[1];
        res.out_z = r[2];
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        t_vec_out want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_checked    <= 0;
            o_pending    <= 0;
            expected_results.delete();
        end else begin
            if (i_start && !i_busy) expected_results.push_back(predict_vector_op(i_item));
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: %p", i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    o_checked <= o_checked + 1;
                    if (want != i_result) o_fail_count <= o_fail_count + 1;
                    if (want.out_x != i_result.out_x)
                        $error("out_x: expected %0d, got %0d", want.out_x, i_result.out_x);
                    if (want.out_y != i_result.out_y)
                        $error("out_y: expected %0d, got %0d", want.out_y, i_result.out_y);
                    if (want.out_z != i_result.out_z)
                        $error("out_z: expected %0d, got %0d", want.out_z, i_result.out_z);
                    if (want.out_scalar != i_result.out_scalar)
                        $error("out_scalar: expected %0d, got %0d",
                               want.out_scalar, i_result.out_scalar);
                    if (want.ok != i_result.ok)
                        $error("ok: expected %0b, got %0b", want.ok, i_result.ok);
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

// ----- bench/vector3_arith_unit_test.sv -----
// Top of the vector unit bench: clock, reset, item stimulus and the verdict.
// Depends on vau_pkg, vector3_arith_unit and vau_result_checker.
module vector3_arith_unit_test
    import vau_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1030;
    // Allow a margin after the last strobe
    localparam int DRAIN_CYCLES = 60;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_vec_in  i_item;
    logic     o_strobe;
    t_vec_out o_result;
    logic     busy_mid;
    int       fail_count;
    int       pending;
    int       checked;
    int       items_sent;

    vector3_arith_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    vau_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sample busy mid-cycle, where it is settled, to decide on acceptance
    always @(negedge i_clk) busy_mid = busy;

    // Hard stop in case the pipe hangs
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // Present one item and hold it until the edge that takes it
    task automatic send_item(input t_vec_in it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy_mid);
        items_sent++;
    endtask

    // Drop start, then idle for the length that the caller asks for
    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_component();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3, 4: return 32'($signed($urandom_range(0, 20)) - 10) << 16;
            5, 6: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_vec_in random_item();
        t_vec_in it;
        it.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                : 4'($urandom_range(0, 11));
        it.a_x = pick_component();
        it.a_y = pick_component();
        it.a_z = pick_component();
        it.b_x = pick_component();
        it.b_y = pick_component();
        it.b_z = pick_component();
        it.c_x = pick_component();
        it.c_y = pick_component();
        it.c_z = pick_component();
        it.scale_factor = pick_component();
        // Hit the zero-length and degenerate-triangle paths now and then
        case ($urandom_range(0, 11))
            0: begin
                it.b_x = it.a_x; it.b_y = it.a_y; it.b_z = it.a_z;
            end
            1: begin
                it.a_x = '0; it.a_y = '0; it.a_z = '0;
            end
            2: begin
                it.c_x = it.b_x; it.c_y = it.b_y; it.c_z = it.b_z;
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_vec_in make_item(input t_opcode op, input logic [31:0] av,
                                          input logic [31:0] bv, input logic [31:0] cv,
                                          input logic [31:0] sv);
        t_vec_in it;
        it = '{opcode: op, a_x: av, a_y: av, a_z: av, b_x: bv, b_y: bv, b_z: bv,
               c_x: cv, c_y: cv, c_z: cv, scale_factor: sv};
        return it;
    endfunction

    initial begin
        t_vec_in it;
        start      = 1'b0;
        i_item     = '0;
        i_rst_n    = 1'b0;
        items_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every opcode at the extremes plus the special cases
        for (int op = 0; op <= 11; op++) begin
            send_item(make_item(t_opcode'(op), 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000));
        end
        // zero-length normalize, coincident and collinear triangle
        send_item(make_item(OP_NORMALIZE, 0, 32'h0001_0000, 0, 0));
        send_item(make_item(OP_NORMAL, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 0));
        it = make_item(OP_NORMAL, 0, 32'h0001_0000, 32'h0002_0000, 0);
        send_item(it);
        // clamp with low bound above high bound: high wins
        send_item(make_item(OP_CLAMP, 32'h0000_0005, 32'h0000_0010, 32'h0000_0008, 0));
        // centroid of a negative sum truncates toward zero
        send_item(make_item(OP_CENTROID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        send_item(make_item(OP_DISTANCE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        send_item(make_item(OP_SCALE, 32'hFFFF_FFFF, 0, 0, 32'h0000_0001));
        // undefined opcodes
        for (int op = 12; op <= 15; op++) begin
            it = make_item(OP_ADD, $urandom, $urandom, $urandom, $urandom);
            it.opcode = 4'(op);
            send_item(it);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Keep a long back-to-back stretch in the middle
            if ((n < 400 || n > 650) && $urandom_range(0, 99) < 30)
                idle_cycles(1);
            // Hold off once until the pipe drains completely
            if (n == 800) begin
                start <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            send_item(random_item());
        end
        start <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items over all twelve opcodes, undefined codes and edge values;",
                 items_sent);
        $display("compared %0d results field by field.", checked);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/vau_pkg.sv
hw/rtl/vau_sqrt.sv
hw/rtl/vau_div.sv
hw/rtl/vector3_arith_unit.sv
bench/vau_result_checker.sv
bench/vector3_arith_unit_test.sv
